FILE: rtl/core/rbv_pkg.sv
// Shared constants and types for the revolution byte vote block.
package rbv_pkg;

   localparam int BYTE_LANES   = 5;
   localparam int REVOLUTIONS  = 5;
   localparam int ACTIVE_LANES = (REVOLUTIONS < BYTE_LANES) ? REVOLUTIONS : BYTE_LANES;
   localparam int BYTE_W       = 8;
   localparam int CNT_W        = $clog2(BYTE_LANES + 1);

   typedef logic [BYTE_W-1:0] lane_byte_type;
   typedef logic [BYTE_LANES-1:0][BYTE_W-1:0] lane_bytes_type;
   typedef logic [BYTE_LANES-1:0] lane_mask_type;

   typedef struct packed {
      lane_mask_type                     ok;
      logic [BYTE_LANES-1:0][CNT_W-1:0] cnt;
   } vote_type;

endpackage

FILE: rtl/core/rbv_req_if.sv
// Input channel carrying one byte position from every revolution.
interface rbv_req_if;
   logic                  valid;
   logic                  ready;
   rbv_pkg::lane_byte_type rev_byte_0;
   rbv_pkg::lane_byte_type rev_byte_1;
   rbv_pkg::lane_byte_type rev_byte_2;
   rbv_pkg::lane_byte_type rev_byte_3;
   rbv_pkg::lane_byte_type rev_byte_4;
   logic [rbv_pkg::BYTE_LANES-1:0] lane_valid;

   modport source (output valid, rev_byte_0, rev_byte_1, rev_byte_2, rev_byte_3,
                   rev_byte_4, lane_valid, input ready);
   modport sink   (input valid, rev_byte_0, rev_byte_1, rev_byte_2, rev_byte_3,
                   rev_byte_4, lane_valid, output ready);
endinterface

FILE: rtl/core/rbv_rsp_if.sv
// Result channel carrying the merged byte and its weak flag.
interface rbv_rsp_if;
   logic                  valid;
   logic                  ready;
   rbv_pkg::lane_byte_type merged_byte;
   logic                  weak_flag;

   modport source (output valid, merged_byte, weak_flag, input ready);
   modport sink   (input valid, merged_byte, weak_flag, output ready);
endinterface

FILE: rtl/core/rbv_count.sv
// Per-lane match counter: how many valid lanes hold the same byte as each lane.
module rbv_count (
   input  rbv_pkg::lane_bytes_type lane_bytes,
   input  rbv_pkg::lane_mask_type  lane_valid,
   output rbv_pkg::vote_type       vote
);

   always_comb begin
      vote = '0;
      for (int r = 0; r < rbv_pkg::BYTE_LANES; r++) begin
         vote.ok[r] = lane_valid[r] && (r < rbv_pkg::ACTIVE_LANES);
      end
      for (int r = 0; r < rbv_pkg::BYTE_LANES; r++) begin
         if (vote.ok[r]) begin
            for (int s = 0; s < rbv_pkg::BYTE_LANES; s++) begin
               vote.cnt[r] = vote.cnt[r] +
                  rbv_pkg::CNT_W'(vote.ok[s] && (lane_bytes[s] == lane_bytes[r]));
            end
         end
      end
   end

endmodule

FILE: rtl/core/rbv_select.sv
// Winner selection: highest count, lowest byte on a tie, and the weak flag.
module rbv_select (
   input  rbv_pkg::lane_bytes_type lane_bytes,
   input  rbv_pkg::vote_type       vote,
   output rbv_pkg::lane_byte_type  merged_byte,
   output logic                    weak_flag
);

   logic [rbv_pkg::CNT_W-1:0] best_cnt;
   rbv_pkg::lane_byte_type    best_val;

   always_comb begin
      best_cnt = '0;
      best_val = '0;
      for (int r = 0; r < rbv_pkg::BYTE_LANES; r++) begin
         if (vote.ok[r] && ((vote.cnt[r] > best_cnt) ||
             ((vote.cnt[r] == best_cnt) && (lane_bytes[r] < best_val)))) begin
            best_cnt = vote.cnt[r];
            best_val = lane_bytes[r];
         end
      end
      weak_flag = 1'b0;
      for (int r = 0; r < rbv_pkg::BYTE_LANES; r++) begin
         if (vote.ok[r] && (lane_bytes[r] != best_val)) begin
            weak_flag = 1'b1;
         end
      end
      merged_byte = best_val;
   end

endmodule

FILE: rtl/core/revolution_byte_vote_core.sv
// Top level of the revolution byte vote block: input stage, vote logic, result register.
//
// This block merges repeated reads of a disk track one byte position per item. Each
// item carries the byte seen in each of five revolutions and a mask of the revolutions
// that reach the position; the result is the most frequent valid byte, the lowest value
// winning a tie, with a weak flag when any valid lane disagrees, or zero with the flag
// clear when no lane is valid. The block accepts one item every clock cycle while the
// result is not stalled. Each item waits in the input register while the lane match
// counters and the winner compare work on it, and the result register then takes the
// answer. A stalled result holds both registers, and the input stays ready as long as
// the result register drains in the same cycle.
module revolution_byte_vote_core (
   input logic        clock,
   input logic        reset,
   rbv_req_if.sink    req_chan,
   rbv_rsp_if.source  rsp_chan
);

   logic                     s1_valid_ff, s1_valid_in;
   rbv_pkg::lane_bytes_type  s1_bytes_ff;
   rbv_pkg::lane_mask_type   s1_mask_ff;
   logic                     out_valid_ff, out_valid_in;
   rbv_pkg::lane_byte_type   merged_ff;
   logic                     weak_ff;

   logic                     s1_advance;
   logic                     req_take;
   rbv_pkg::vote_type        vote;
   rbv_pkg::lane_byte_type   merged_calc;
   logic                     weak_calc;

   assign s1_advance     = !out_valid_ff || rsp_chan.ready;
   assign req_chan.ready = !s1_valid_ff || s1_advance;
   assign req_take       = req_chan.valid && req_chan.ready;

   assign s1_valid_in  = req_take ? 1'b1 : (s1_advance ? 1'b0 : s1_valid_ff);
   assign out_valid_in = s1_advance ? s1_valid_ff : out_valid_ff;

   rbv_count u_count (
      .lane_bytes (s1_bytes_ff),
      .lane_valid (s1_mask_ff),
      .vote       (vote)
   );

   rbv_select u_select (
      .lane_bytes  (s1_bytes_ff),
      .vote        (vote),
      .merged_byte (merged_calc),
      .weak_flag   (weak_calc)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_bytes_ff <= {req_chan.rev_byte_4, req_chan.rev_byte_3, req_chan.rev_byte_2,
                         req_chan.rev_byte_1, req_chan.rev_byte_0};
         s1_mask_ff  <= req_chan.lane_valid;
      end
      if (s1_advance && s1_valid_ff) begin
         merged_ff <= merged_calc;
         weak_ff   <= weak_calc;
      end
   end

   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.merged_byte = merged_ff;
   assign rsp_chan.weak_flag   = weak_ff;

   // A held input item must not move while the result register is stalled.
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_advance) |=> (s1_valid_ff && $stable(s1_bytes_ff)
                                        && $stable(s1_mask_ff)))
      else $error("input stage changed while stalled");

   // An item with no valid lane yields a zero byte and a clear weak flag.
   a_empty: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s1_advance && (vote.ok == '0)) |=>
         (rsp_chan.valid && (rsp_chan.merged_byte == '0) && !rsp_chan.weak_flag))
      else $error("empty item gave nonzero result");

   // A single valid lane can never be weak.
   a_single: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s1_advance && $onehot(vote.ok)) |=> !rsp_chan.weak_flag)
      else $error("single lane flagged weak");

   // The input stalls only when both stages are full and the result is not taken.
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !req_chan.ready |-> (s1_valid_ff && out_valid_ff && !rsp_chan.ready))
      else $error("input stalled without back pressure");

endmodule
